[design/hsv_to_rgb_converter_macros.svh]
// assertion macros shared by the hsv to rgb converter modules
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define HSV2RGB_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("hsv2rgb assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define HSV2RGB_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("hsv2rgb assertion failed");

`endif

[design/hsv2rgb_pkg.sv]
// shared constants, sector codes and stage payload types of the hsv to rgb converter
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  localparam int HUE_BITS     = 16;
  localparam int CHANNEL_BITS = 8;
  localparam int FRAC_BITS    = 16;
  localparam int SECTOR_BITS  = 3;
  localparam int ARG_BITS     = CHANNEL_BITS + FRAC_BITS;
  localparam int NUM_BITS     = 2 * CHANNEL_BITS + FRAC_BITS;

  localparam logic [CHANNEL_BITS-1:0] CH_MAX   = '1;
  localparam logic [ARG_BITS-1:0]     DEN      = {CH_MAX, {FRAC_BITS{1'b0}}};
  localparam logic [NUM_BITS-1:0]     HALF_DEN = NUM_BITS'(DEN >> 1);

  typedef enum logic [SECTOR_BITS-1:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } rgb_t;

  typedef struct packed {
    sector_t                 sector;
    logic [FRAC_BITS-1:0]    frac;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] brightness;
  } stage1_t;

  typedef struct packed {
    sector_t                 sector;
    logic [ARG_BITS-1:0]     prod_q;
    logic [ARG_BITS-1:0]     prod_t;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] brightness;
  } stage2_t;

  typedef struct packed {
    sector_t                 sector;
    logic [NUM_BITS-1:0]     num_p;
    logic [NUM_BITS-1:0]     num_q;
    logic [NUM_BITS-1:0]     num_t;
    logic [CHANNEL_BITS-1:0] brightness;
  } stage3_t;

endpackage

[design/hsv2rgb_sector.sv]
// first stage: hue times six, split into sector and position fraction
`timescale 1ns / 1ps

module hsv2rgb_sector (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    hsv_valid,
  input  hsv2rgb_pkg::hsv_t       hsv,
  output logic                    hsv_ready,
  output logic                    s1_valid,
  output hsv2rgb_pkg::stage1_t    s1,
  input  logic                    s1_ready
);

  localparam int HB = hsv2rgb_pkg::HUE_BITS;
  localparam int FB = hsv2rgb_pkg::FRAC_BITS;

  logic [HB+2:0]    hue6;
  logic [HB+FB-1:0] frac_wide;
  hsv2rgb_pkg::stage1_t s1_next;

  assign hue6      = (HB+3)'(hsv.hue) * (HB+3)'(6);
  assign frac_wide = {hue6[HB-1:0], {FB{1'b0}}} >> HB;

  always_comb begin
    s1_next.sector     = hsv2rgb_pkg::sector_t'(hue6[HB+2:HB]);
    s1_next.frac       = frac_wide[FB-1:0];
    s1_next.saturation = hsv.saturation;
    s1_next.brightness = hsv.brightness;
  end

  assign hsv_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (hsv_ready) begin
      s1_valid <= hsv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hsv_ready && hsv_valid) begin
      s1 <= s1_next;
    end
  end

endmodule

[design/hsv2rgb_scale.sv]
// second and third stages: saturation products, then brightness products
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_macros.svh"

module hsv2rgb_scale (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s1_valid,
  input  hsv2rgb_pkg::stage1_t    s1,
  output logic                    s1_ready,
  output logic                    s3_valid,
  output hsv2rgb_pkg::stage3_t    s3,
  input  logic                    s3_ready
);

  localparam int FB = hsv2rgb_pkg::FRAC_BITS;
  localparam int AB = hsv2rgb_pkg::ARG_BITS;
  localparam int NB = hsv2rgb_pkg::NUM_BITS;

  logic                 s2_valid;
  hsv2rgb_pkg::stage2_t s2;
  hsv2rgb_pkg::stage2_t s2_next;
  hsv2rgb_pkg::stage3_t s3_next;
  logic                 s2_ready;
  logic [FB:0]          frac_rest;
  logic [AB:0]          prod_t_full;
  logic [AB-1:0]        arg_p;
  logic [AB-1:0]        arg_q;
  logic [AB-1:0]        arg_t;

  // stage 2: s*f and s*(1-f)
  assign frac_rest   = {1'b1, {FB{1'b0}}} - {1'b0, s1.frac};
  assign prod_t_full = (AB+1)'(s1.saturation) * (AB+1)'(frac_rest);

  always_comb begin
    s2_next.sector     = s1.sector;
    s2_next.prod_q     = AB'(s1.saturation) * AB'(s1.frac);
    s2_next.prod_t     = prod_t_full[AB-1:0];
    s2_next.saturation = s1.saturation;
    s2_next.brightness = s1.brightness;
  end

  // stage 3: v times (1 - term)
  assign arg_p = {hsv2rgb_pkg::CH_MAX - s2.saturation, {FB{1'b0}}};
  assign arg_q = hsv2rgb_pkg::DEN - s2.prod_q;
  assign arg_t = hsv2rgb_pkg::DEN - s2.prod_t;

  always_comb begin
    s3_next.sector     = s2.sector;
    s3_next.num_p      = NB'(s2.brightness) * NB'(arg_p);
    s3_next.num_q      = NB'(s2.brightness) * NB'(arg_q);
    s3_next.num_t      = NB'(s2.brightness) * NB'(arg_t);
    s3_next.brightness = s2.brightness;
  end

  assign s2_ready = !s3_valid || s3_ready;
  assign s1_ready = !s2_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s2_valid <= s1_valid;
      end
      if (s2_ready) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      s2 <= s2_next;
    end
    if (s2_ready && s2_valid) begin
      s3 <= s3_next;
    end
  end

  `HSV2RGB_ASSERT_NEXT(a_s2_advances, s2_valid && s2_ready, s3_valid)

endmodule

[design/hsv2rgb_round.sv]
// fourth stage: round and divide by full scale, route by sector into the output register
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_macros.svh"

module hsv2rgb_round (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s3_valid,
  input  hsv2rgb_pkg::stage3_t    s3,
  output logic                    s3_ready,
  output logic                    rgb_valid,
  output hsv2rgb_pkg::rgb_t       rgb,
  input  logic                    rgb_stall
);

  localparam int CB = hsv2rgb_pkg::CHANNEL_BITS;
  localparam int FB = hsv2rgb_pkg::FRAC_BITS;
  localparam int NB = hsv2rgb_pkg::NUM_BITS;

  // floor((num + den/2) / den), den = max * 2^frac
  function automatic logic [CB-1:0] div_round(input logic [NB-1:0] num);
    logic [NB-1:0]   biased;
    logic [2*CB-1:0] y;
    logic [CB:0]     rem;
    logic [CB:0]     quo;
    biased = num + hsv2rgb_pkg::HALF_DEN;
    y      = biased[NB-1:FB];
    rem    = {1'b0, y[2*CB-1:CB]} + {1'b0, y[CB-1:0]};
    quo    = {1'b0, y[2*CB-1:CB]}
           + (CB+1)'(rem >= {1'b0, hsv2rgb_pkg::CH_MAX})
           + (CB+1)'(rem >= {hsv2rgb_pkg::CH_MAX, 1'b0});
    return quo[CB-1:0];
  endfunction

  logic [CB-1:0]     p_val;
  logic [CB-1:0]     q_val;
  logic [CB-1:0]     t_val;
  logic [CB-1:0]     v_val;
  hsv2rgb_pkg::rgb_t rgb_next;

  assign p_val = div_round(s3.num_p);
  assign q_val = div_round(s3.num_q);
  assign t_val = div_round(s3.num_t);
  assign v_val = s3.brightness;

  always_comb begin
    unique case (s3.sector)
      hsv2rgb_pkg::SEC_RY: rgb_next = '{red: v_val, green: t_val, blue: p_val};
      hsv2rgb_pkg::SEC_YG: rgb_next = '{red: q_val, green: v_val, blue: p_val};
      hsv2rgb_pkg::SEC_GC: rgb_next = '{red: p_val, green: v_val, blue: t_val};
      hsv2rgb_pkg::SEC_CB: rgb_next = '{red: p_val, green: q_val, blue: v_val};
      hsv2rgb_pkg::SEC_BM: rgb_next = '{red: t_val, green: p_val, blue: v_val};
      default:             rgb_next = '{red: v_val, green: p_val, blue: q_val};
    endcase
  end

  assign s3_ready = !rgb_valid || !rgb_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_valid <= 1'b0;
    end else if (s3_ready) begin
      rgb_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s3_valid) begin
      rgb <= rgb_next;
    end
  end

  `HSV2RGB_ASSERT_NOW(a_p_smallest, s3_valid, (p_val <= q_val) && (p_val <= t_val))
  `HSV2RGB_ASSERT_NOW(a_v_largest, s3_valid, (q_val <= v_val) && (t_val <= v_val))

endmodule

[design/hsv_to_rgb_converter.sv]
// HSV to RGB pixel converter. Takes one pixel per clock while hsv_stall is low, as hue
// (16-bit fraction of a full turn), saturation and value (8 bits, 255 = 1.0) and returns
// red, green and blue with p, q and t rounded to nearest, ties up. Throughput is one
// transaction per cycle while the output is not stalled. The four register stages are hue
// scaling, saturation products, brightness products, and rounding with sector routing; an
// accepted input passes through them in that order before rgb_valid rises. Each stage holds
// its own valid bit, so bubbles close up under output stall and hsv_stall rises only when
// all four stages are full and the output is stalled.
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter (
  input  logic              clk,
  input  logic              rst,
  input  logic              hsv_valid,
  output logic              hsv_stall,
  input  hsv2rgb_pkg::hsv_t hsv,
  output logic              rgb_valid,
  input  logic              rgb_stall,
  output hsv2rgb_pkg::rgb_t rgb
);

  logic                 hsv_ready;
  logic                 s1_valid;
  logic                 s1_ready;
  hsv2rgb_pkg::stage1_t s1;
  logic                 s3_valid;
  logic                 s3_ready;
  hsv2rgb_pkg::stage3_t s3;

  hsv2rgb_sector u_sector (
    .clk       (clk),
    .rst       (rst),
    .hsv_valid (hsv_valid),
    .hsv       (hsv),
    .hsv_ready (hsv_ready),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .s1_ready  (s1_ready)
  );

  hsv2rgb_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s1_ready (s1_ready),
    .s3_valid (s3_valid),
    .s3       (s3),
    .s3_ready (s3_ready)
  );

  hsv2rgb_round u_round (
    .clk       (clk),
    .rst       (rst),
    .s3_valid  (s3_valid),
    .s3        (s3),
    .s3_ready  (s3_ready),
    .rgb_valid (rgb_valid),
    .rgb       (rgb),
    .rgb_stall (rgb_stall)
  );

  assign hsv_stall = !hsv_ready;

  `HSV2RGB_ASSERT_NOW(a_stall_only_when_full, hsv_stall, rgb_valid && rgb_stall && s1_valid)

endmodule
